// File: design/owb_pkg.sv
// Shared types and constants of the one-wire bus master.
package owb_pkg;

   // Configuration port geometry
   localparam int CsrIndexW = 3;
   localparam int CsrDataW  = 10;

   // Configuration register indexes
   localparam logic [CsrIndexW-1:0] REG_RESET_LOW     = 3'd0;
   localparam logic [CsrIndexW-1:0] REG_RESET_RELEASE = 3'd1;
   localparam logic [CsrIndexW-1:0] REG_POLL_INTERVAL = 3'd2;
   localparam logic [CsrIndexW-1:0] REG_POLL_LIMIT    = 3'd3;
   localparam logic [CsrIndexW-1:0] REG_SLOT_LONG     = 3'd4;
   localparam logic [CsrIndexW-1:0] REG_SLOT_SHORT    = 3'd5;
   localparam logic [CsrIndexW-1:0] REG_READ_SAMPLE   = 3'd6;
   localparam logic [CsrIndexW-1:0] REG_READ_RECOVERY = 3'd7;

   // Register defaults
   localparam logic [9:0] RESET_LOW_DEFAULT     = 10'd780;
   localparam logic [9:0] RESET_RELEASE_DEFAULT = 10'd40;
   localparam logic [7:0] POLL_INTERVAL_DEFAULT = 8'd15;
   localparam logic [4:0] POLL_LIMIT_DEFAULT    = 5'd16;
   localparam logic [7:0] SLOT_LONG_DEFAULT     = 8'd60;
   localparam logic [7:0] SLOT_SHORT_DEFAULT    = 8'd2;
   localparam logic [7:0] READ_SAMPLE_DEFAULT   = 8'd9;
   localparam logic [7:0] READ_RECOVERY_DEFAULT = 8'd45;

   // Command codes
   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_RESET = 2'd1;
   localparam logic [1:0] MODE_WRITE = 2'd2;
   localparam logic [1:0] MODE_READ  = 2'd3;

   // Reset result codes
   localparam logic [1:0] STATUS_PRESENT = 2'd0;
   localparam logic [1:0] STATUS_TIMEOUT = 2'd1;
   localparam logic [1:0] STATUS_STUCK   = 2'd2;

   localparam logic [4:0] POLL_COUNT_MAX = 5'd31;
   localparam logic [2:0] LAST_BIT       = 3'd7;

   typedef struct packed {
      logic [9:0] reset_low_time;
      logic [9:0] reset_release_time;
      logic [7:0] poll_interval;
      logic [4:0] poll_limit;
      logic [7:0] slot_long_time;
      logic [7:0] slot_short_time;
      logic [7:0] read_sample_delay;
      logic [7:0] read_recovery_time;
   } cfg_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] tx_byte;
      logic       bus_level;
   } req_item_type;

endpackage

// File: design/owb_if.sv
// Request and response channel interfaces of the one-wire bus master.
interface owb_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] tx_byte;
   logic       bus_level;

   modport source (output valid, output mode, output tx_byte, output bus_level, input ready);
   modport sink   (input valid, input mode, input tx_byte, input bus_level, output ready);
endinterface

interface owb_rsp_if;
   logic       valid;
   logic       ready;
   logic       drive_low;
   logic       busy_res;
   logic       done_res;
   logic [1:0] status;
   logic [7:0] rx_byte;

   modport source (output valid, output drive_low, output busy_res, output done_res,
                   output status, output rx_byte, input ready);
   modport sink   (input valid, input drive_low, input busy_res, input done_res,
                   input status, input rx_byte, output ready);
endinterface

// File: design/owb_csr.sv
// Configuration register file of the one-wire bus master.
module owb_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [owb_pkg::CsrIndexW-1:0]   csr_index,
   input  logic [owb_pkg::CsrDataW-1:0]    csr_wdata,
   output owb_pkg::cfg_type                cfg
);

   owb_pkg::cfg_type cfg_ff;
   owb_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            owb_pkg::REG_RESET_LOW:     cfg_in.reset_low_time     = csr_wdata[9:0];
            owb_pkg::REG_RESET_RELEASE: cfg_in.reset_release_time = csr_wdata[9:0];
            owb_pkg::REG_POLL_INTERVAL: cfg_in.poll_interval      = csr_wdata[7:0];
            owb_pkg::REG_POLL_LIMIT:    cfg_in.poll_limit         = csr_wdata[4:0];
            owb_pkg::REG_SLOT_LONG:     cfg_in.slot_long_time     = csr_wdata[7:0];
            owb_pkg::REG_SLOT_SHORT:    cfg_in.slot_short_time    = csr_wdata[7:0];
            owb_pkg::REG_READ_SAMPLE:   cfg_in.read_sample_delay  = csr_wdata[7:0];
            owb_pkg::REG_READ_RECOVERY: cfg_in.read_recovery_time = csr_wdata[7:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_time     <= owb_pkg::RESET_LOW_DEFAULT;
         cfg_ff.reset_release_time <= owb_pkg::RESET_RELEASE_DEFAULT;
         cfg_ff.poll_interval      <= owb_pkg::POLL_INTERVAL_DEFAULT;
         cfg_ff.poll_limit         <= owb_pkg::POLL_LIMIT_DEFAULT;
         cfg_ff.slot_long_time     <= owb_pkg::SLOT_LONG_DEFAULT;
         cfg_ff.slot_short_time    <= owb_pkg::SLOT_SHORT_DEFAULT;
         cfg_ff.read_sample_delay  <= owb_pkg::READ_SAMPLE_DEFAULT;
         cfg_ff.read_recovery_time <= owb_pkg::READ_RECOVERY_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: design/owb_core.sv
// Bus timing state machine and result register of the one-wire bus master.
module owb_core #(
   parameter int TIMER_BITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  owb_pkg::cfg_type      cfg,
   input  logic                  item_valid,
   input  owb_pkg::req_item_type item,
   output logic                  item_ready,
   owb_rsp_if.source             rsp
);

   localparam int TimerMax = (1 << TIMER_BITS) - 1;
   localparam int WideW    = (TIMER_BITS > 10) ? TIMER_BITS : 10;

   typedef enum logic [3:0] {
      PH_IDLE, PH_RLOW, PH_RREL, PH_PLOW, PH_PHIGH,
      PH_WA, PH_WB, PH_RDL, PH_RDS, PH_RDC
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [TIMER_BITS-1:0] time_left_ff, time_left_in;
   logic [2:0]            bit_index_ff, bit_index_in;
   logic [7:0]            shift_reg_ff, shift_reg_in;
   logic [4:0]            poll_count_ff, poll_count_in;
   logic [1:0]            last_status_ff, last_status_in;
   logic [7:0]            rx_hold_ff, rx_hold_in;

   logic                  rsp_valid_ff;
   logic                  drive_ff, drive_in;
   logic                  busy_ff;
   logic                  done_ff, done_in;

   phase_type             ph_cur;
   logic                  tick_last;
   logic [TIMER_BITS-1:0] tl_dec;
   logic                  fire;

   // Clamp a duration: zero counts as one tick, saturate at the timer range
   function automatic logic [TIMER_BITS-1:0] dur(input logic [9:0] v);
      logic [WideW-1:0] wide;
      wide = WideW'(v);
      if (wide == '0) begin
         wide = WideW'(1);
      end else if (wide > WideW'(TimerMax)) begin
         wide = WideW'(TimerMax);
      end
      return TIMER_BITS'(wide);
   endfunction

   assign item_ready = !rsp_valid_ff || rsp.ready;
   assign fire       = item_valid && item_ready;

   always_comb begin
      phase_in       = phase_ff;
      time_left_in   = time_left_ff;
      bit_index_in   = bit_index_ff;
      shift_reg_in   = shift_reg_ff;
      poll_count_in  = poll_count_ff;
      last_status_in = last_status_ff;
      rx_hold_in     = rx_hold_ff;
      drive_in       = 1'b0;
      done_in        = 1'b0;

      // Start a command on an idle tick; that tick is its first phase tick
      if (phase_ff == PH_IDLE) begin
         unique case (item.mode)
            owb_pkg::MODE_RESET: begin
               phase_in     = PH_RLOW;
               time_left_in = dur(cfg.reset_low_time);
            end
            owb_pkg::MODE_WRITE: begin
               shift_reg_in = item.tx_byte;
               bit_index_in = '0;
               phase_in     = PH_WA;
               time_left_in = dur(10'(item.tx_byte[0] ? cfg.slot_short_time
                                                     : cfg.slot_long_time));
            end
            owb_pkg::MODE_READ: begin
               shift_reg_in = '0;
               bit_index_in = '0;
               phase_in     = PH_RDL;
               time_left_in = TIMER_BITS'(1);
            end
            default: begin
            end
         endcase
      end

      ph_cur    = phase_in;
      tick_last = (time_left_in <= TIMER_BITS'(1));
      tl_dec    = tick_last ? '0 : time_left_in - TIMER_BITS'(1);

      unique case (ph_cur)
         PH_RLOW: begin
            drive_in     = 1'b1;
            time_left_in = tl_dec;
            if (tick_last) begin
               phase_in     = PH_RREL;
               time_left_in = dur(cfg.reset_release_time);
            end
         end
         PH_RREL: begin
            time_left_in = tl_dec;
            if (tick_last) begin
               phase_in      = PH_PLOW;
               time_left_in  = '0;
               poll_count_in = '0;
            end
         end
         PH_PLOW, PH_PHIGH: begin
            if (time_left_in != '0) begin
               // Wait out the poll interval, then give up once the poll count has reached the limit
               time_left_in = tl_dec;
               if (tick_last && poll_count_in >= cfg.poll_limit) begin
                  last_status_in = (ph_cur == PH_PLOW) ? owb_pkg::STATUS_TIMEOUT
                                                       : owb_pkg::STATUS_STUCK;
                  phase_in       = PH_IDLE;
                  done_in        = 1'b1;
               end
            end else if (item.bus_level == (ph_cur == PH_PHIGH)) begin
               if (ph_cur == PH_PLOW) begin
                  phase_in      = PH_PHIGH;
                  poll_count_in = '0;
               end else begin
                  last_status_in = owb_pkg::STATUS_PRESENT;
                  phase_in       = PH_IDLE;
                  done_in        = 1'b1;
               end
            end else begin
               if (poll_count_in != owb_pkg::POLL_COUNT_MAX) begin
                  poll_count_in = poll_count_in + 5'd1;
               end
               time_left_in = dur(10'(cfg.poll_interval));
            end
         end
         PH_WA: begin
            drive_in     = 1'b1;
            time_left_in = tl_dec;
            if (tick_last) begin
               phase_in     = PH_WB;
               time_left_in = dur(10'(shift_reg_in[0] ? cfg.slot_long_time
                                                      : cfg.slot_short_time));
            end
         end
         PH_WB: begin
            time_left_in = tl_dec;
            if (tick_last) begin
               shift_reg_in = {1'b0, shift_reg_in[7:1]};
               if (bit_index_in == owb_pkg::LAST_BIT) begin
                  phase_in = PH_IDLE;
                  done_in  = 1'b1;
               end else begin
                  bit_index_in = bit_index_in + 3'd1;
                  phase_in     = PH_WA;
                  time_left_in = dur(10'(shift_reg_in[0] ? cfg.slot_short_time
                                                         : cfg.slot_long_time));
               end
            end
         end
         PH_RDL: begin
            drive_in     = 1'b1;
            time_left_in = tl_dec;
            if (tick_last) begin
               phase_in     = PH_RDS;
               time_left_in = dur(10'(cfg.read_sample_delay));
            end
         end
         PH_RDS: begin
            time_left_in = tl_dec;
            if (tick_last) begin
               shift_reg_in = {item.bus_level, shift_reg_in[7:1]};
               phase_in     = PH_RDC;
               time_left_in = dur(10'(cfg.read_recovery_time));
            end
         end
         PH_RDC: begin
            time_left_in = tl_dec;
            if (tick_last) begin
               if (bit_index_in == owb_pkg::LAST_BIT) begin
                  rx_hold_in = shift_reg_in;
                  phase_in   = PH_IDLE;
                  done_in    = 1'b1;
               end else begin
                  bit_index_in = bit_index_in + 3'd1;
                  phase_in     = PH_RDL;
                  time_left_in = TIMER_BITS'(1);
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         time_left_ff   <= '0;
         bit_index_ff   <= '0;
         shift_reg_ff   <= '0;
         poll_count_ff  <= '0;
         last_status_ff <= owb_pkg::STATUS_PRESENT;
         rx_hold_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (fire) begin
            phase_ff       <= phase_in;
            time_left_ff   <= time_left_in;
            bit_index_ff   <= bit_index_in;
            shift_reg_ff   <= shift_reg_in;
            poll_count_ff  <= poll_count_in;
            last_status_ff <= last_status_in;
            rx_hold_ff     <= rx_hold_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         drive_ff <= drive_in;
         busy_ff  <= (phase_in != PH_IDLE);
         done_ff  <= done_in;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.drive_low = drive_ff;
   assign rsp.busy_res  = busy_ff;
   assign rsp.done_res  = done_ff;
   assign rsp.status    = last_status_ff;
   assign rsp.rx_byte   = rx_hold_ff;

endmodule

// File: design/one_wire_bus_master.sv
// A request passes the input register, then the result register, before its result reaches rsp_chan.
// Throughput: one request transfer per cycle while rsp_chan is ready; each transfer is one microsecond tick.
// The input register takes a new request while the result register still waits on rsp_chan only if it is empty.
// Reset (synchronous, active high) empties both registers, idles the state machine and
// restores every configuration register to its default; no clearing pass is needed.
module one_wire_bus_master #(
   parameter int TIMER_BITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [owb_pkg::CsrIndexW-1:0] csr_index,
   input  logic [owb_pkg::CsrDataW-1:0]  csr_wdata,
   owb_req_if.sink                       req_chan,
   owb_rsp_if.source                     rsp_chan
);

   owb_pkg::cfg_type      cfg;
   owb_pkg::req_item_type in_item_ff;
   owb_pkg::req_item_type in_item_in;
   logic                  in_valid_ff;
   logic                  core_ready;

   // Configuration registers; to be written only while the bus is idle, which the block itself does not enforce
   owb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Input register: refill whenever empty or drained into the core this cycle
   assign req_chan.ready = !in_valid_ff || core_ready;

   always_comb begin
      in_item_in.mode      = req_chan.mode;
      in_item_in.tx_byte   = req_chan.tx_byte;
      in_item_in.bus_level = req_chan.bus_level;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   // Hold the payload while the core is stalled by the response side
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_item_ff <= in_item_in;
      end
   end

   // One tick of bus timing per transfer; state and result register live here
   owb_core #(
      .TIMER_BITS (TIMER_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (in_valid_ff),
      .item       (in_item_ff),
      .item_ready (core_ready),
      .rsp        (rsp_chan)
   );

`ifndef NO_ASSERTIONS
   // A finished command never reports itself busy on the same tick
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.done_res |-> !rsp_chan.busy_res)
      else $error("done and busy reported together");

   // Status only ever carries a defined reset result
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.status == owb_pkg::STATUS_PRESENT ||
                          rsp_chan.status == owb_pkg::STATUS_TIMEOUT ||
                          rsp_chan.status == owb_pkg::STATUS_STUCK))
      else $error("undefined status code");

   // A held item stays put until the core takes it
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !core_ready |=> in_valid_ff && $stable(in_item_ff))
      else $error("held input item lost or changed");

   // A tick taken by the core always yields a result on the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && core_ready |=> rsp_chan.valid)
      else $error("processed tick gave no result");

   // Reset leaves both registers empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !in_valid_ff && !rsp_chan.valid)
      else $error("registers not empty after reset");
`endif

endmodule
